### rtl/core/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int MAG_W = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_RED = 3'd4
  } cmd_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

### rtl/core/rational_arithmetic_unit.sv
// Channel | Direction | Handshake           | Payload
// in      | sink      | in_valid/in_stall   | cmd a_num a_den b_num b_den
// out     | source    | out_valid/out_stall | res_num res_den status
//
// One item at a time. Up to three 33x33 products on one shared multiplier (one
// per cycle), a cross-term add, then a binary (Stein) gcd that shares the 64-bit
// subtractor for gu-gv (gv-gu has its own), then two restoring divides by the
// gcd at one quotient bit a cycle. An error or zero result is set in S_CHK,
// after S_MUL1, S_MUL2 (S_MUL3 for add and subtract) and S_ADD; any other
// result also waits on the gcd loop and the 128 divide steps.
// rst clears the sequencer and the output valid. in_stall is high whenever
// the unit is busy or a result waits; a stalled result holds.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] res_num,
  output logic [62:0]        res_den,
  output logic               status
);

  localparam int OW = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_CHK, S_GSH, S_GLOOP, S_GFIN,
    S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t state;

  // Operand sign/magnitude
  logic        an_s, ad_s, bn_s, bd_s;
  logic [OW:0] an_m, ad_m, bn_m, bd_m;
  logic [2:0]  cmd_r;

  // Products and result sign/magnitude
  logic              p1_s, p2_s, num_s, den_s;
  logic [MAG_W-1:0]  p1_m, p2_m, num_m, den_m;

  // gcd registers
  logic [MAG_W-1:0]  gu, gv, g;
  logic [6:0]        gk;

  // divider
  logic [MAG_W-1:0]  dq, dr, nm;
  logic [6:0]        dcnt;

  // multiplier shared by all product cycles
  logic [OW:0]        mx, my;
  logic [2*OW+1:0]    mprod;
  logic [MAG_W-1:0]   mres;

  function automatic logic [OW:0] mag_of(input logic [31:0] raw);
    logic [OW-1:0] v;
    begin
      v = raw[OW-1:0];
      mag_of = v[OW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    end
  endfunction

  always_comb begin
    mx = an_m;
    my = bd_m;
    unique case (state)
      S_MUL1: begin
        if (cmd_r[2]) begin
          mx = an_m; my = {{OW{1'b0}}, 1'b1};
        end else if (cmd_r == CMD_MUL) begin
          mx = an_m; my = bn_m;
        end else begin
          mx = an_m; my = bd_m;
        end
      end
      S_MUL2: begin
        if (cmd_r[2]) begin
          mx = ad_m; my = {{OW{1'b0}}, 1'b1};
        end else if (cmd_r == CMD_DIV) begin
          mx = ad_m; my = bn_m;
        end else if (cmd_r == CMD_MUL) begin
          mx = ad_m; my = bd_m;
        end else begin
          mx = bn_m; my = ad_m;
        end
      end
      S_MUL3: begin
        mx = ad_m; my = bd_m;
      end
      default: begin
        mx = an_m; my = bd_m;
      end
    endcase
  end
  assign mprod = mx * my;
  assign mres  = MAG_W'(mprod);

  // shared subtract: gcd difference and divider trial subtract
  logic [MAG_W:0]   sub_a, sub_b, sub_d;
  logic [MAG_W-1:0] dr_sh;
  logic [MAG_W-1:0] dsrc;
  assign dsrc  = (state == S_DIVN) ? num_m : den_m;
  assign dr_sh = {dr[MAG_W-2:0], dsrc[6'(MAG_W-1) - dcnt[5:0]]};
  always_comb begin
    if (state == S_GLOOP) begin
      sub_a = {1'b0, gu};
      sub_b = {1'b0, gv};
    end else begin
      sub_a = {dr[MAG_W-1], dr_sh};
      sub_b = {1'b0, g};
    end
  end
  assign sub_d = sub_a - sub_b;

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_acc) begin
          cmd_r <= cmd;
          an_s <= a_num[OW-1]; an_m <= mag_of(a_num);
          ad_s <= a_den[OW-1]; ad_m <= mag_of(a_den);
          bn_s <= b_num[OW-1]; bn_m <= mag_of(b_num);
          bd_s <= b_den[OW-1]; bd_m <= mag_of(b_den);
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1_m <= mres;
          p1_s <= cmd_r[2] ? an_s : (an_s ^ ((cmd_r == CMD_MUL) ? bn_s : bd_s));
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2_m <= mres;
          if (cmd_r[2])
            p2_s <= ad_s;
          else if (cmd_r == CMD_DIV)
            p2_s <= ad_s ^ bn_s;
          else if (cmd_r == CMD_MUL)
            p2_s <= ad_s ^ bd_s;
          else
            p2_s <= bn_s ^ ad_s ^ (cmd_r == CMD_SUB);
          if (cmd_r[2] || cmd_r == CMD_MUL || cmd_r == CMD_DIV)
            state <= S_ADD;
          else
            state <= S_MUL3;
        end
        S_MUL3: begin
          // add/sub denominator ad*bd
          den_m <= mres;
          den_s <= ad_s ^ bd_s;
          state <= S_ADD;
        end
        S_ADD: begin
          if (cmd_r[2] || cmd_r == CMD_MUL || cmd_r == CMD_DIV) begin
            num_m <= p1_m; num_s <= p1_s;
            den_m <= p2_m; den_s <= p2_s;
          end else begin
            if (p1_s == p2_s) begin
              num_m <= p1_m + p2_m; num_s <= p1_s;
            end else if (p1_m >= p2_m) begin
              num_m <= p1_m - p2_m; num_s <= p1_s;
            end else begin
              num_m <= p2_m - p1_m; num_s <= p2_s;
            end
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (ad_m == '0 || (!cmd_r[2] && bd_m == '0) || den_m == '0) begin
            res_num <= '0; res_den <= '0; status <= STATUS_ERR;
            out_valid <= 1'b1; state <= S_IDLE;
          end else if (num_m == '0) begin
            res_num <= '0; res_den <= 63'd1; status <= STATUS_OK;
            out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            gu <= num_m; gv <= den_m; gk <= '0;
            state <= S_GSH;
          end
        end
        S_GSH: begin
          // strip common factors of two
          if (!gu[0] && !gv[0]) begin
            gu <= gu >> 1; gv <= gv >> 1; gk <= gk + 7'd1;
          end else begin
            state <= S_GLOOP;
          end
        end
        S_GLOOP: begin
          if (!gu[0]) gu <= gu >> 1;
          else if (!gv[0]) gv <= gv >> 1;
          else if (gu == gv) state <= S_GFIN;
          else if (!sub_d[MAG_W]) gu <= sub_d[MAG_W-1:0] >> 1;
          else gv <= (gv - gu) >> 1;
        end
        S_GFIN: begin
          g <= gu << gk[5:0];
          dr <= '0; dcnt <= '0;
          state <= S_DIVN;
        end
        S_DIVN, S_DIVD: begin
          dq <= {dq[MAG_W-2:0], !sub_d[MAG_W]};
          if (dcnt == 7'(MAG_W-1)) begin
            dcnt <= '0;
            dr <= '0;
            if (state == S_DIVN) begin
              state <= S_DIVD;
              nm <= {dq[MAG_W-2:0], !sub_d[MAG_W]};
            end else begin
              state <= S_DONE;
            end
          end else begin
            dcnt <= dcnt + 7'd1;
            dr <= !sub_d[MAG_W] ? sub_d[MAG_W-1:0] : dr_sh;
          end
        end
        S_DONE: begin
          if (num_s != den_s)
            res_num <= -nm;
          else
            res_num <= nm[MAG_W-1] ? {1'b0, {(MAG_W-1){1'b1}}} : nm;
          res_den <= dq[62:0];
          status <= STATUS_OK;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ERR) |-> (res_den == '0 && res_num == '0))
    else $error("error result not zero");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_OK) |-> (res_den != '0))
    else $error("ok result with zero denominator");
  a_gcd_nz: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN) |-> (g != '0)) else $error("zero divisor");

endmodule
